// File: rtl/fpp_pkg.sv
// Shared types, character codes and lookup functions of the position string parser.
package fpp_pkg;

   // Board store geometry: two banks of 64 squares, one 4-bit piece code each.
   localparam int PIECE_WIDTH  = 4;
   localparam int BOARD_DEPTH  = 128;
   localparam int BOARD_ADDR_W = 7;
   localparam int SQUARE_W     = 6;

   // Characters of the notation.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_6     = 8'h36;
   localparam logic [7:0] CHAR_8     = 8'h38;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_B  = 8'h62;
   localparam logic [7:0] CHAR_LC_H  = 8'h68;
   localparam logic [7:0] CHAR_LC_W  = 8'h77;

   // Command codes of a request.
   localparam logic CMD_FEED = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Piece codes.
   localparam logic [3:0] PC_EMPTY = 4'd0;
   localparam logic [3:0] PC_WP = 4'd1;
   localparam logic [3:0] PC_WN = 4'd2;
   localparam logic [3:0] PC_WB = 4'd3;
   localparam logic [3:0] PC_WR = 4'd4;
   localparam logic [3:0] PC_WQ = 4'd5;
   localparam logic [3:0] PC_WK = 4'd6;
   localparam logic [3:0] PC_BP = 4'd9;
   localparam logic [3:0] PC_BN = 4'd10;
   localparam logic [3:0] PC_BB = 4'd11;
   localparam logic [3:0] PC_BR = 4'd12;
   localparam logic [3:0] PC_BQ = 4'd13;
   localparam logic [3:0] PC_BK = 4'd14;

   // Default castling rights: all four.
   localparam logic [3:0] CASTLE_ALL = 4'hF;

   // Per-request result handed from the parser to the output stage.
   typedef struct packed {
      logic                parse_done;
      logic                parse_valid;
      logic                black_to_move;
      logic [3:0]          castle_rights;
      logic                ep_present;
      logic [2:0]          ep_file;
      logic                ep_rank;
      logic [15:0]         halfmove_count;
      logic [15:0]         fullmove_count;
      logic                is_read;
      logic                show_start;
      logic                entry_written;
      logic [SQUARE_W-1:0] square;
   } fpp_result_type;

   // Piece code of a board letter, empty for anything else.
   function automatic logic [3:0] piece_of(input logic [7:0] c);
      logic [3:0] p;
      case (c)
         8'h50:   p = PC_WP;
         8'h4E:   p = PC_WN;
         8'h42:   p = PC_WB;
         8'h52:   p = PC_WR;
         8'h51:   p = PC_WQ;
         8'h4B:   p = PC_WK;
         8'h70:   p = PC_BP;
         8'h6E:   p = PC_BN;
         8'h62:   p = PC_BB;
         8'h72:   p = PC_BR;
         8'h71:   p = PC_BQ;
         8'h6B:   p = PC_BK;
         default: p = PC_EMPTY;
      endcase
      return p;
   endfunction

   // Castling right bit of a castling letter, zero for anything else.
   function automatic logic [3:0] castle_bit(input logic [7:0] c);
      logic [3:0] b;
      case (c)
         8'h4B:   b = 4'b1000;
         8'h51:   b = 4'b0100;
         8'h6B:   b = 4'b0010;
         8'h71:   b = 4'b0001;
         default: b = 4'b0000;
      endcase
      return b;
   endfunction

   // Standard start position, square index is rank field times eight plus file.
   function automatic logic [3:0] start_piece(input logic [SQUARE_W-1:0] sq);
      logic [3:0] p;
      case (sq[5:3])
         3'd0: begin
            case (sq[2:0])
               3'd0, 3'd7: p = PC_BR;
               3'd1, 3'd6: p = PC_BN;
               3'd2, 3'd5: p = PC_BB;
               3'd3:       p = PC_BQ;
               default:    p = PC_BK;
            endcase
         end
         3'd1:    p = PC_BP;
         3'd6:    p = PC_WP;
         3'd7: begin
            case (sq[2:0])
               3'd0, 3'd7: p = PC_WR;
               3'd1, 3'd6: p = PC_WN;
               3'd2, 3'd5: p = PC_WB;
               3'd3:       p = PC_WQ;
               default:    p = PC_WK;
            endcase
         end
         default: p = PC_EMPTY;
      endcase
      return p;
   endfunction

endpackage

// File: rtl/fpp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module fpp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fpp_parse.sv
// Character parser: phase machine, position registers and board store access.
module fpp_parse #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 command,
   input  logic [7:0]                           char_code,
   input  logic                                 end_of_string,
   input  logic [fpp_pkg::SQUARE_W-1:0]         square_index,
   output logic                                 ram_wr_en,
   output logic [fpp_pkg::BOARD_ADDR_W-1:0]     ram_wr_addr,
   output logic [fpp_pkg::PIECE_WIDTH-1:0]      ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [fpp_pkg::BOARD_ADDR_W-1:0]     ram_rd_addr,
   output fpp_pkg::fpp_result_type              result
);
   import fpp_pkg::*;

   typedef enum logic [3:0] {
      PH_BOARD,
      PH_SIDE,
      PH_SIDE_SP,
      PH_CAS_FIRST,
      PH_CAS_LET,
      PH_CAS_SP,
      PH_EP_FIRST,
      PH_EP_RANK,
      PH_EP_SP,
      PH_HALF,
      PH_FULL,
      PH_TRAIL
   } phase_type;

   localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX = {COUNTER_WIDTH{1'b1}};
   localparam logic [COUNTER_WIDTH-1:0] COUNT_ONE = COUNTER_WIDTH'(1);

   phase_type                phase_ff, phase_in;
   logic [3:0]               rank_ff, rank_in;
   logic [4:0]               file_ff, file_in;
   logic                     error_ff, error_in;
   logic                     live_ff, live_in;
   logic                     show_ff, show_in;
   logic                     black_ff, black_in;
   logic [3:0]               castle_ff, castle_in;
   logic                     ep_present_ff, ep_present_in;
   logic [2:0]               ep_file_ff, ep_file_in;
   logic                     ep_rank_ff, ep_rank_in;
   logic [COUNTER_WIDTH-1:0] half_ff, half_in;
   logic [COUNTER_WIDTH-1:0] full_ff, full_in;
   logic [BOARD_DEPTH-1:0]   written_ff, written_in;

   logic                     feed;
   logic                     shadow;
   logic                     clear_shadow;
   logic                     done;
   logic                     valid;
   logic [3:0]               piece;
   logic [3:0]               cbit;
   logic [4:0]               file_sum;
   logic [7:0]               ep_offset;
   logic [COUNTER_WIDTH+15:0] half_ext;
   logic [COUNTER_WIDTH+15:0] full_ext;

   // Append one decimal digit to a counter, saturating at its maximum.
   function automatic logic [COUNTER_WIDTH-1:0] count_digit(
      input logic [COUNTER_WIDTH-1:0] v,
      input logic [7:0]               c
   );
      logic [COUNTER_WIDTH+3:0] n;
      logic [7:0]               d;
      d = c - CHAR_0;
      n = {v, 3'b000} + {2'b00, v, 1'b0} + (COUNTER_WIDTH+4)'(d[3:0]);
      if (c < CHAR_0 || c > CHAR_9) begin
         return v;
      end else if (n > (COUNTER_WIDTH+4)'(COUNT_MAX)) begin
         return COUNT_MAX;
      end else begin
         return n[COUNTER_WIDTH-1:0];
      end
   endfunction

   assign feed      = accept && (command == CMD_FEED);
   assign shadow    = ~live_ff;
   assign piece     = piece_of(char_code);
   assign cbit      = castle_bit(char_code);
   assign file_sum  = file_ff + char_code[4:0] - CHAR_0[4:0];
   assign ep_offset = char_code - CHAR_LC_A;

   // Next state of the parser for the accepted request.
   always_comb begin
      phase_in      = phase_ff;
      rank_in       = rank_ff;
      file_in       = file_ff;
      error_in      = error_ff;
      live_in       = live_ff;
      show_in       = show_ff;
      black_in      = black_ff;
      castle_in     = castle_ff;
      ep_present_in = ep_present_ff;
      ep_file_in    = ep_file_ff;
      ep_rank_in    = ep_rank_ff;
      half_in       = half_ff;
      full_in       = full_ff;
      ram_wr_en     = 1'b0;
      clear_shadow  = 1'b0;
      done          = 1'b0;
      valid         = 1'b0;

      if (feed) begin
         clear_shadow = (phase_ff == PH_BOARD) && (rank_ff == 4'd0) &&
                        (file_ff == 5'd0) && !error_ff;
         if (!error_ff) begin
            case (phase_ff)
               PH_BOARD: begin
                  if (char_code == CHAR_SLASH || char_code == CHAR_SPACE) begin
                     rank_in = rank_ff + 4'd1;
                     file_in = 5'd0;
                     if (rank_ff >= 4'd7) begin
                        phase_in = PH_SIDE;
                     end
                  end else if (char_code >= CHAR_1 && char_code <= CHAR_8) begin
                     file_in = (file_sum > 5'd16) ? 5'd16 : file_sum;
                  end else if (file_ff >= 5'd8 || piece == PC_EMPTY) begin
                     error_in = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     file_in   = file_ff + 5'd1;
                  end
               end
               PH_SIDE: begin
                  if (char_code == CHAR_LC_W || char_code == CHAR_LC_B) begin
                     black_in = (char_code == CHAR_LC_B);
                     phase_in = PH_SIDE_SP;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_SIDE_SP: begin
                  if (char_code == CHAR_SPACE) begin
                     castle_in = 4'd0;
                     file_in   = 5'd0;
                     phase_in  = PH_CAS_FIRST;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_CAS_FIRST, PH_CAS_LET: begin
                  if (char_code == CHAR_SPACE) begin
                     phase_in = PH_EP_FIRST;
                  end else if (phase_ff == PH_CAS_FIRST && char_code == CHAR_DASH) begin
                     phase_in = PH_CAS_SP;
                  end else if (cbit != 4'd0 && file_ff < 5'd4) begin
                     castle_in = castle_ff | cbit;
                     file_in   = file_ff + 5'd1;
                     phase_in  = PH_CAS_LET;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_CAS_SP: begin
                  if (char_code == CHAR_SPACE) begin
                     phase_in = PH_EP_FIRST;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_EP_SP: begin
                  if (char_code == CHAR_SPACE) begin
                     half_in  = '0;
                     phase_in = PH_HALF;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_EP_FIRST: begin
                  // The en passant fields are cleared whatever the character.
                  ep_present_in = 1'b0;
                  ep_file_in    = 3'd0;
                  ep_rank_in    = 1'b0;
                  if (char_code == CHAR_DASH) begin
                     phase_in = PH_EP_SP;
                  end else if (char_code >= CHAR_LC_A && char_code <= CHAR_LC_H) begin
                     ep_file_in = ep_offset[2:0];
                     phase_in   = PH_EP_RANK;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_EP_RANK: begin
                  if (char_code == CHAR_3 || char_code == CHAR_6) begin
                     ep_present_in = 1'b1;
                     ep_rank_in    = (char_code == CHAR_6);
                     phase_in      = PH_EP_SP;
                  end else begin
                     error_in = 1'b1;
                  end
               end
               PH_HALF: begin
                  if (char_code == CHAR_SPACE) begin
                     full_in  = '0;
                     phase_in = PH_FULL;
                  end else begin
                     half_in = count_digit(half_ff, char_code);
                  end
               end
               PH_FULL: begin
                  if (char_code == CHAR_SPACE) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     full_in = count_digit(full_ff, char_code);
                  end
               end
               default: begin
               end
            endcase
         end

         // Final character: commit the shadow bank or fall back to the start position.
         if (end_of_string) begin
            done  = 1'b1;
            valid = !error_in && (phase_in == PH_FULL || phase_in == PH_TRAIL);
            if (valid) begin
               live_in = ~live_ff;
               show_in = 1'b0;
            end else begin
               show_in       = 1'b1;
               black_in      = 1'b0;
               castle_in     = CASTLE_ALL;
               ep_present_in = 1'b0;
               ep_file_in    = 3'd0;
               ep_rank_in    = 1'b0;
               half_in       = '0;
               full_in       = COUNT_ONE;
            end
            phase_in = PH_BOARD;
            rank_in  = 4'd0;
            file_in  = 5'd0;
            error_in = 1'b0;
         end
      end
   end

   // Written marks: the shadow bank reads as empty until a square is placed.
   always_comb begin
      written_in = written_ff;
      if (clear_shadow) begin
         if (shadow) begin
            written_in[BOARD_DEPTH-1:BOARD_DEPTH/2] = '0;
         end else begin
            written_in[BOARD_DEPTH/2-1:0] = '0;
         end
      end
      if (ram_wr_en) begin
         written_in[ram_wr_addr] = 1'b1;
      end
   end

   // Board store access: placements go to the shadow bank, reads to the live bank.
   assign ram_wr_addr = {shadow, rank_ff[2:0], file_ff[2:0]};
   assign ram_wr_data = piece;
   assign ram_rd_en   = accept && (command == CMD_READ);
   assign ram_rd_addr = {live_ff, square_index};

   // Counters are shown by their low sixteen bits.
   assign half_ext = (COUNTER_WIDTH+16)'(half_in);
   assign full_ext = (COUNTER_WIDTH+16)'(full_in);

   always_comb begin
      result.parse_done     = done;
      result.parse_valid    = valid;
      result.black_to_move  = black_in;
      result.castle_rights  = castle_in;
      result.ep_present     = ep_present_in;
      result.ep_file        = ep_file_in;
      result.ep_rank        = ep_rank_in;
      result.halfmove_count = half_ext[15:0];
      result.fullmove_count = full_ext[15:0];
      result.is_read        = (command == CMD_READ);
      result.show_start     = show_ff;
      result.entry_written  = written_ff[ram_rd_addr];
      result.square         = square_index;
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_BOARD;
         rank_ff       <= 4'd0;
         file_ff       <= 5'd0;
         error_ff      <= 1'b0;
         live_ff       <= 1'b0;
         show_ff       <= 1'b1;
         black_ff      <= 1'b0;
         castle_ff     <= CASTLE_ALL;
         ep_present_ff <= 1'b0;
         ep_file_ff    <= 3'd0;
         ep_rank_ff    <= 1'b0;
         half_ff       <= '0;
         full_ff       <= COUNT_ONE;
         written_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         rank_ff       <= rank_in;
         file_ff       <= file_in;
         error_ff      <= error_in;
         live_ff       <= live_in;
         show_ff       <= show_in;
         black_ff      <= black_in;
         castle_ff     <= castle_in;
         ep_present_ff <= ep_present_in;
         ep_file_ff    <= ep_file_in;
         ep_rank_ff    <= ep_rank_in;
         half_ff       <= half_in;
         full_ff       <= full_in;
         written_ff    <= written_in;
      end
   end

endmodule

// File: rtl/fpp_out.sv
// Read-data stage and output register of the response channel.
module fpp_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  fpp_pkg::fpp_result_type         result,
   input  logic [fpp_pkg::PIECE_WIDTH-1:0] ram_rd_data,
   output logic                            req_ready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,
   output logic                            rsp_tlast
);
   import fpp_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   fpp_result_type s1_res_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff;
   logic           rsp_last_ff;
   logic           s1_advance;
   logic [3:0]     square_piece;
   logic [47:0]    s1_data;

   // The read stage moves on when the output register is empty or being taken.
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);

   // Piece of the read square: start position, stored code, or empty if never placed.
   always_comb begin
      if (!s1_res_ff.is_read) begin
         square_piece = PC_EMPTY;
      end else if (s1_res_ff.show_start) begin
         square_piece = start_piece(s1_res_ff.square);
      end else if (s1_res_ff.entry_written) begin
         square_piece = ram_rd_data;
      end else begin
         square_piece = PC_EMPTY;
      end
   end

   assign s1_data = {1'b0, square_piece, s1_res_ff.fullmove_count,
                     s1_res_ff.halfmove_count, s1_res_ff.ep_rank, s1_res_ff.ep_file,
                     s1_res_ff.ep_present, s1_res_ff.castle_rights,
                     s1_res_ff.black_to_move, s1_res_ff.parse_valid};

   // Control flags of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of both stages.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
      if (s1_advance) begin
         rsp_data_ff <= s1_data;
         rsp_last_ff <= s1_res_ff.parse_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/fen_position_parser_core.sv
// Top level of the chess position string parser.
//
// The request channel carries either one character of a position string
// (tuser low) or a read of one board square (tuser high); tlast marks the
// final character of a string. Every request yields exactly one response
// with the side to move, castling rights, en passant square and both move
// counters; tlast on the response marks a request that ended a string, and
// a read response also carries the piece on the requested square.
// A string is parsed into a shadow bank of the board memory and committed
// at its final character when it is well formed; otherwise the standard
// start position and default fields are shown again.
// Requests pass the read stage and the output register; one is taken every
// cycle while req_tready is high, each with one pass through the parser
// registers and at most one access to the single-port-write board memory.
// After reset the start position is shown and no clearing pass is needed.
// When the receiver stalls, one response waits in the output register and
// one more in the read stage; after that the request side stalls.
module fen_position_parser_core #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // char_code[7:0], square_index[13:8], zero[15:14]
   input  logic        req_tuser,  // command[0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // parse_valid[0], black_to_move[1], castle_rights[5:2], ep_present[6],
   // ep_file[9:7], ep_rank[10], halfmove_count[26:11], fullmove_count[42:27],
   // square_piece[46:43], zero[47]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast   // parse_done
);
   import fpp_pkg::*;

   logic                    accept;
   logic                    ram_wr_en;
   logic [BOARD_ADDR_W-1:0] ram_wr_addr;
   logic [PIECE_WIDTH-1:0]  ram_wr_data;
   logic                    ram_rd_en;
   logic [BOARD_ADDR_W-1:0] ram_rd_addr;
   logic [PIECE_WIDTH-1:0]  ram_rd_data;
   fpp_result_type          result;

   assign accept = req_tvalid && req_tready;

   // Parser and position registers.
   fpp_parse #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_tuser),
      .char_code     (req_tdata[7:0]),
      .end_of_string (req_tlast),
      .square_index  (req_tdata[13:8]),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .result        (result)
   );

   // Two-bank board memory.
   fpp_ram #(
      .WIDTH (PIECE_WIDTH),
      .DEPTH (BOARD_DEPTH)
   ) u_board (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Read stage and response register.
   fpp_out u_out (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .result      (result),
      .ram_rd_data (ram_rd_data),
      .req_ready   (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
